FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the raster sampler RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

FILE: rtl/core/rbs_pkg.sv
// ----------------------------------------------------------------------------
// rbs_pkg
// Types and fixed constants shared by the raster bilinear sampler modules.
// ----------------------------------------------------------------------------
package rbs_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int COORD_BITS  = FRAC_BITS + 2;
    localparam int Q_BITS      = FRAC_BITS + 1;
    localparam int ACC_BITS    = 64;
    localparam int SAMPLE_BITS = 48;
    localparam int TOP_BITS    = 48;
    localparam int PADDR_BITS  = 4;
    localparam int PDATA_BITS  = 32;

    localparam logic [Q_BITS-1:0] ONE_Q = Q_BITS'(1) << FRAC_BITS;

    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_SAMPLE = 2'd2;

    localparam logic [1:0] CORNER_LAST = 2'd3;

    // blend sequence steps
    localparam logic [2:0] MAC_TOP0   = 3'd0;
    localparam logic [2:0] MAC_TOP1   = 3'd1;
    localparam logic [2:0] MAC_BOT0   = 3'd2;
    localparam logic [2:0] MAC_BOT1   = 3'd3;
    localparam logic [2:0] MAC_VTOP_L = 3'd4;
    localparam logic [2:0] MAC_VTOP_H = 3'd5;
    localparam logic [2:0] MAC_VBOT_L = 3'd6;
    localparam logic [2:0] MAC_VBOT_H = 3'd7;

    typedef struct packed {
        logic [7:0] width;
        logic [7:0] height;
        logic [2:0] chans;
    } rbs_cfg_t;

    typedef struct packed {
        logic       load;
        logic       clear_step;
        logic       scale;
        logic       corner_calc;
        logic       addr1;
        logic       addr2;
        logic       mem_wr;
        logic       mem_rd;
        logic       fetch;
        logic       mac_en;
        logic [2:0] mac_step;
        logic [1:0] corner;
        logic       result_load;
    } rbs_cmd_t;

    typedef struct packed {
        logic       clear_last;
        logic [1:0] kind;
        logic       ok;
        logic       out_busy;
    } rbs_status_t;

endpackage

FILE: rtl/core/raster_bilinear_sampler.sv
// ----------------------------------------------------------------------------
// raster_bilinear_sampler
// Multi-channel raster store with pixel read/write and bilinear sampling.
// ----------------------------------------------------------------------------
// After reset the block zeroes its raster memory, one element per cycle,
// over all MAX_WIDTH*MAX_HEIGHT*MAX_CHANNELS elements (65536 at the defaults);
// in_stall stays high until then, while APB writes are taken as usual. Each
// transaction is handled alone on a single-port memory: a write or read runs
// through dispatch, the address steps and the memory access, a transaction
// that is out of range or of unused kind goes from dispatch to the result,
// and a sample runs scaling, four address/read rounds, then eight steps of a
// shared 32x17 multiply-accumulate. A finished result sits in an output
// register, so the next transaction is accepted while it waits.
module raster_bilinear_sampler
    import rbs_pkg::*;
#(
    parameter int MAX_WIDTH    = 128,
    parameter int MAX_HEIGHT   = 128,
    parameter int MAX_CHANNELS = 4
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [PADDR_BITS-1:0]        paddr,
    input  logic [PDATA_BITS-1:0]        pwdata,
    output logic [PDATA_BITS-1:0]        prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   kind,
    input  logic [7:0]                   pix_x,
    input  logic [7:0]                   pix_y,
    input  logic [2:0]                   chan,
    input  logic [31:0]                  write_value,
    input  logic signed [COORD_BITS-1:0] coord_u,
    input  logic signed [COORD_BITS-1:0] coord_v,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [31:0]                  read_value,
    output logic [SAMPLE_BITS-1:0]       sample_value,
    output logic                         in_range
);

    rbs_cfg_t    cfg;
    rbs_cmd_t    cmd;
    rbs_status_t status;

    rbs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    rbs_datapath #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .status       (status),
        .kind         (kind),
        .pix_x        (pix_x),
        .pix_y        (pix_y),
        .chan         (chan),
        .write_value  (write_value),
        .coord_u      (coord_u),
        .coord_v      (coord_v),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .read_value   (read_value),
        .sample_value (sample_value),
        .in_range     (in_range)
    );

endmodule

FILE: rtl/core/rbs_regs.sv
// ----------------------------------------------------------------------------
// rbs_regs
// APB configuration registers: raster width, raster height, channel count.
// ----------------------------------------------------------------------------
module rbs_regs
    import rbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready,
    output rbs_cfg_t              cfg
);

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_CHANS  = 2'd2;

    logic [7:0] width_reg;
    logic [7:0] height_reg;
    logic [2:0] chans_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 8'd128;
            height_reg <= 8'd128;
            chans_reg  <= 3'd4;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_WIDTH:  width_reg  <= pwdata[7:0];
                REG_HEIGHT: height_reg <= pwdata[7:0];
                REG_CHANS:  chans_reg  <= pwdata[2:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = {24'd0, width_reg};
            REG_HEIGHT: prdata = {24'd0, height_reg};
            REG_CHANS:  prdata = {29'd0, chans_reg};
            default:    prdata = '0;
        endcase
    end

    assign cfg.width  = width_reg;
    assign cfg.height = height_reg;
    assign cfg.chans  = chans_reg;

endmodule

FILE: rtl/core/rbs_ctrl.sv
// ----------------------------------------------------------------------------
// rbs_ctrl
// Sequencer: memory clear after reset, address steps, corner fetches, blend.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rbs_ctrl
    import rbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  rbs_status_t status,
    output rbs_cmd_t    cmd
);

    typedef enum logic [10:0] {
        ST_CLEAR    = 11'b00000000001,
        ST_IDLE     = 11'b00000000010,
        ST_DISPATCH = 11'b00000000100,
        ST_SCALE    = 11'b00000001000,
        ST_CORNER   = 11'b00000010000,
        ST_ADDR1    = 11'b00000100000,
        ST_ADDR2    = 11'b00001000000,
        ST_MEM      = 11'b00010000000,
        ST_FETCH    = 11'b00100000000,
        ST_MAC      = 11'b01000000000,
        ST_DONE     = 11'b10000000000
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] corner_reg;
    logic [1:0] corner_next;
    logic [2:0] step_reg;
    logic [2:0] step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            corner_reg <= '0;
            step_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            corner_reg <= corner_next;
            step_reg   <= step_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        corner_next = corner_reg;
        step_next   = step_reg;
        cmd         = '0;
        cmd.corner   = corner_reg;
        cmd.mac_step = step_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                corner_next = '0;
                step_next   = MAC_TOP0;
                if (!status.ok)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    case (status.kind)
                        KIND_WRITE:  state_next = ST_ADDR1;
                        KIND_READ:   state_next = ST_ADDR1;
                        KIND_SAMPLE: state_next = ST_SCALE;
                        default:     state_next = ST_DONE;
                    endcase
                end
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_CORNER;
            end
            ST_CORNER:
            begin
                cmd.corner_calc = 1'b1;
                state_next      = ST_ADDR1;
            end
            ST_ADDR1:
            begin
                cmd.addr1  = 1'b1;
                state_next = ST_ADDR2;
            end
            ST_ADDR2:
            begin
                cmd.addr2  = 1'b1;
                state_next = ST_MEM;
            end
            ST_MEM:
            begin
                if (status.kind == KIND_WRITE)
                begin
                    cmd.mem_wr = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.mem_rd = 1'b1;
                    state_next = (status.kind == KIND_READ) ? ST_DONE : ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.fetch = 1'b1;
                if (corner_reg == CORNER_LAST)
                begin
                    state_next = ST_MAC;
                end
                else
                begin
                    corner_next = corner_reg + 2'd1;
                    state_next  = ST_ADDR1;
                end
            end
            ST_MAC:
            begin
                cmd.mac_en = 1'b1;
                step_next  = step_reg + 3'd1;
                if (step_reg == MAC_VBOT_H)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ASSERT_CLK(a_accept_dispatch, clk, rst_n,
        (state_reg == ST_IDLE && in_valid) |=> (state_reg == ST_DISPATCH),
        "accepted transaction did not reach dispatch")
    `ASSERT_CLK(a_blend_after_corners, clk, rst_n,
        (state_reg == ST_FETCH && corner_reg == CORNER_LAST) |=>
            (state_reg == ST_MAC && step_reg == MAC_TOP0),
        "blend did not start at first step after last corner")

endmodule

FILE: rtl/core/rbs_datapath.sv
// ----------------------------------------------------------------------------
// rbs_datapath
// Raster memory, address arithmetic, coordinate scaling, blend MAC, output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rbs_datapath
    import rbs_pkg::*;
#(
    parameter int MAX_WIDTH    = 128,
    parameter int MAX_HEIGHT   = 128,
    parameter int MAX_CHANNELS = 4
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  rbs_cfg_t                cfg,
    input  rbs_cmd_t                cmd,
    output rbs_status_t             status,
    input  logic [1:0]              kind,
    input  logic [7:0]              pix_x,
    input  logic [7:0]              pix_y,
    input  logic [2:0]              chan,
    input  logic [31:0]             write_value,
    input  logic signed [COORD_BITS-1:0] coord_u,
    input  logic signed [COORD_BITS-1:0] coord_v,
    input  logic                    out_stall,
    output logic                    out_valid,
    output logic [31:0]             read_value,
    output logic [SAMPLE_BITS-1:0]  sample_value,
    output logic                    in_range
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
    localparam int AB    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PB    = (MAX_WIDTH * MAX_HEIGHT > 1) ? $clog2(MAX_WIDTH * MAX_HEIGHT) : 1;
    localparam int WB    = $clog2(MAX_WIDTH + 1);
    localparam int HB    = $clog2(MAX_HEIGHT + 1);
    localparam int NB    = $clog2(MAX_CHANNELS + 1);
    localparam int WB1   = WB + 1;
    localparam int HB1   = HB + 1;
    localparam int XB    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YB    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int FXB   = Q_BITS + WB;
    localparam int FYB   = Q_BITS + HB;
    localparam int PRODB = VALUE_BITS + Q_BITS;

    logic [WB-1:0] eff_w;
    logic [HB-1:0] eff_h;
    logic [NB-1:0] eff_c;

    always_comb
    begin
        if (cfg.width == '0)
            eff_w = WB'(1);
        else if (32'(cfg.width) > MAX_WIDTH)
            eff_w = WB'(MAX_WIDTH);
        else
            eff_w = WB'(cfg.width);

        if (cfg.height == '0)
            eff_h = HB'(1);
        else if (32'(cfg.height) > MAX_HEIGHT)
            eff_h = HB'(MAX_HEIGHT);
        else
            eff_h = HB'(cfg.height);

        if (cfg.chans == '0)
            eff_c = NB'(1);
        else if (32'(cfg.chans) > MAX_CHANNELS)
            eff_c = NB'(MAX_CHANNELS);
        else
            eff_c = NB'(cfg.chans);
    end

    // input capture
    logic                  x_ok;
    logic                  y_ok;
    logic                  c_ok;
    logic                  ok_in;
    logic [Q_BITS-1:0]     u_clamp;
    logic [Q_BITS-1:0]     v_clamp;

    assign x_ok = 32'(pix_x) < 32'(eff_w);
    assign y_ok = 32'(pix_y) < 32'(eff_h);
    assign c_ok = 32'(chan) < 32'(eff_c);

    always_comb
    begin
        case (kind)
            KIND_WRITE:  ok_in = x_ok && y_ok && c_ok;
            KIND_READ:   ok_in = x_ok && y_ok && c_ok;
            KIND_SAMPLE: ok_in = c_ok;
            default:     ok_in = 1'b0;
        endcase
    end

    assign u_clamp = coord_u[COORD_BITS-1] ? '0 :
                     ((coord_u[Q_BITS-1:0] > ONE_Q) ? ONE_Q : coord_u[Q_BITS-1:0]);
    assign v_clamp = coord_v[COORD_BITS-1] ? '0 :
                     ((coord_v[Q_BITS-1:0] > ONE_Q) ? ONE_Q : coord_v[Q_BITS-1:0]);

    logic [1:0]            kind_reg;
    logic                  ok_reg;
    logic [2:0]            chan_reg;
    logic [VALUE_BITS-1:0] wval_reg;
    logic [Q_BITS-1:0]     u_reg;
    logic [Q_BITS-1:0]     v_reg;
    logic [XB-1:0]         x0_reg;
    logic [XB-1:0]         x1_reg;
    logic [YB-1:0]         y0_reg;
    logic [YB-1:0]         y1_reg;
    logic [FXB-1:0]        fx_reg;
    logic [FYB-1:0]        fy_reg;
    logic [FRAC_BITS-1:0]  tx_reg;
    logic [FRAC_BITS-1:0]  ty_reg;
    logic [PB-1:0]         pix_reg;
    logic [AB-1:0]         addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= '0;
            ok_reg   <= 1'b0;
        end
        else if (cmd.load)
        begin
            kind_reg <= kind;
            ok_reg   <= ok_in;
        end
    end

    // corner and address arithmetic
    logic [WB1-1:0] x0_next;
    logic [WB1-1:0] x0_inc;
    logic [HB1-1:0] y0_next;
    logic [HB1-1:0] y0_inc;
    logic [XB-1:0]  x_sel;
    logic [YB-1:0]  y_sel;

    assign x0_next = WB1'(fx_reg[FXB-1:FRAC_BITS]);
    assign y0_next = HB1'(fy_reg[FYB-1:FRAC_BITS]);
    assign x0_inc  = x0_next + WB1'(1);
    assign y0_inc  = y0_next + HB1'(1);
    assign x_sel   = cmd.corner[0] ? x1_reg : x0_reg;
    assign y_sel   = cmd.corner[1] ? y1_reg : y0_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            chan_reg <= chan;
            wval_reg <= VALUE_BITS'(write_value);
            u_reg    <= u_clamp;
            v_reg    <= v_clamp;
            x0_reg   <= XB'(pix_x);
            y0_reg   <= YB'(pix_y);
        end
        if (cmd.scale)
        begin
            fx_reg <= FXB'(u_reg) * FXB'(eff_w - WB'(1));
            fy_reg <= FYB'(v_reg) * FYB'(eff_h - HB'(1));
        end
        if (cmd.corner_calc)
        begin
            x0_reg <= XB'(x0_next);
            y0_reg <= YB'(y0_next);
            x1_reg <= (x0_inc < WB1'(eff_w)) ? XB'(x0_inc) : XB'(x0_next);
            y1_reg <= (y0_inc < HB1'(eff_h)) ? YB'(y0_inc) : YB'(y0_next);
            tx_reg <= fx_reg[FRAC_BITS-1:0];
            ty_reg <= fy_reg[FRAC_BITS-1:0];
        end
        if (cmd.addr1)
        begin
            pix_reg <= PB'(PB'(y_sel) * PB'(eff_w)) + PB'(x_sel);
        end
        if (cmd.addr2)
        begin
            addr_reg <= AB'(AB'(pix_reg) * AB'(eff_c)) + AB'(chan_reg);
        end
    end

    // raster memory, zero-filled by the clear sweep after reset
    logic [VALUE_BITS-1:0] mem [DEPTH];
    logic [VALUE_BITS-1:0] rdata_reg;
    logic [AB-1:0]         clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (cmd.clear_step)
            clr_cnt_reg <= clr_cnt_reg + AB'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
            mem[clr_cnt_reg] <= '0;
        else if (cmd.mem_wr)
            mem[addr_reg] <= wval_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_rd)
            rdata_reg <= mem[addr_reg];
    end

    // blend: shared 32x17 multiply-accumulate, one product per step
    logic [VALUE_BITS-1:0] corner_reg [4];
    logic [TOP_BITS-1:0]   top_reg;
    logic [TOP_BITS-1:0]   bot_reg;
    logic [ACC_BITS-1:0]   acc_reg;
    logic [VALUE_BITS-1:0] mac_a;
    logic [Q_BITS-1:0]     mac_b;
    logic [Q_BITS-1:0]     wx0;
    logic [Q_BITS-1:0]     wy0;
    logic [PRODB-1:0]      prod;
    logic [ACC_BITS-1:0]   term;
    logic                  mac_hi;
    logic                  mac_clr;

    assign wx0 = ONE_Q - Q_BITS'(tx_reg);
    assign wy0 = ONE_Q - Q_BITS'(ty_reg);

    always_comb
    begin
        mac_hi  = 1'b0;
        mac_clr = 1'b0;
        case (cmd.mac_step)
            MAC_TOP0:
            begin
                mac_a   = corner_reg[0];
                mac_b   = wx0;
                mac_clr = 1'b1;
            end
            MAC_TOP1:
            begin
                mac_a = corner_reg[1];
                mac_b = Q_BITS'(tx_reg);
            end
            MAC_BOT0:
            begin
                mac_a   = corner_reg[2];
                mac_b   = wx0;
                mac_clr = 1'b1;
            end
            MAC_BOT1:
            begin
                mac_a = corner_reg[3];
                mac_b = Q_BITS'(tx_reg);
            end
            MAC_VTOP_L:
            begin
                mac_a   = top_reg[31:0];
                mac_b   = wy0;
                mac_clr = 1'b1;
            end
            MAC_VTOP_H:
            begin
                mac_a  = VALUE_BITS'(top_reg[TOP_BITS-1:32]);
                mac_b  = wy0;
                mac_hi = 1'b1;
            end
            MAC_VBOT_L:
            begin
                mac_a = bot_reg[31:0];
                mac_b = Q_BITS'(ty_reg);
            end
            MAC_VBOT_H:
            begin
                mac_a  = VALUE_BITS'(bot_reg[TOP_BITS-1:32]);
                mac_b  = Q_BITS'(ty_reg);
                mac_hi = 1'b1;
            end
            default:
            begin
                mac_a = '0;
                mac_b = '0;
            end
        endcase
    end

    assign prod = PRODB'(mac_a) * PRODB'(mac_b);
    assign term = mac_hi ? (ACC_BITS'(prod) << 32) : ACC_BITS'(prod);

    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
            corner_reg[cmd.corner] <= rdata_reg;
        if (cmd.mac_en)
        begin
            acc_reg <= mac_clr ? term : (acc_reg + term);
            if (cmd.mac_step == MAC_BOT0)
                top_reg <= acc_reg[TOP_BITS-1:0];
            if (cmd.mac_step == MAC_VTOP_L)
                bot_reg <= acc_reg[TOP_BITS-1:0];
        end
    end

    // output register
    logic                   out_valid_reg;
    logic [31:0]            read_value_reg;
    logic [SAMPLE_BITS-1:0] sample_value_reg;
    logic                   in_range_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.result_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            read_value_reg   <= (kind_reg == KIND_READ && ok_reg) ? 32'(rdata_reg) : '0;
            sample_value_reg <= (kind_reg == KIND_SAMPLE && ok_reg) ?
                                acc_reg[FRAC_BITS +: SAMPLE_BITS] : '0;
            in_range_reg     <= ok_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_value   = read_value_reg;
    assign sample_value = sample_value_reg;
    assign in_range     = in_range_reg;

    assign status.clear_last = (clr_cnt_reg == AB'(DEPTH - 1));
    assign status.kind       = kind_reg;
    assign status.ok         = ok_reg;
    assign status.out_busy   = out_valid_reg && out_stall;

    `ASSERT_CLK(a_load_when_free, clk, rst_n,
        cmd.result_load |-> !(out_valid_reg && out_stall),
        "result loaded over a stalled transaction")
    `ASSERT_NEVER(a_clear_exclusive, clk, rst_n,
        cmd.clear_step && (cmd.mem_wr || cmd.mem_rd),
        "memory access during clear sweep")

endmodule

FILE: test/tb_raster_bilinear_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_raster_bilinear_sampler
// Self-checking bench for the raster store: pixel writes, pixel reads and
// bilinear samples go through a directed table, then random traffic runs
// under a series of raster geometries. Each result, predicted by a local model
// of the store or fixed by the table, is compared field by field with the DUT.
// ----------------------------------------------------------------------------
module tb_raster_bilinear_sampler;
    import rbs_pkg::*;

    localparam int MAX_W = 128;
    localparam int MAX_H = 128;
    localparam int MAX_C = 4;
    localparam int STORE_DEPTH = MAX_W * MAX_H * MAX_C;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [PADDR_BITS-1:0] ADDR_WIDTH  = 4'h0;
    localparam logic [PADDR_BITS-1:0] ADDR_HEIGHT = 4'h4;
    localparam logic [PADDR_BITS-1:0] ADDR_CHANS  = 4'h8;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT = 200000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int RANDOM_PER_PHASE = 125;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         x;
        logic [7:0]         y;
        logic [2:0]         ch;
        logic [31:0]        wval;
        logic signed [17:0] u;
        logic signed [17:0] v;
    } raster_txn_t;

    typedef struct packed {
        logic [31:0] rd;
        logic [47:0] smp;
        logic        ok;
    } raster_result_t;

    typedef struct packed {
        raster_txn_t    txn;
        logic           fixed;
        raster_result_t res;
    } directed_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_BITS-1:0]  paddr = '0;
    logic [PDATA_BITS-1:0]  pwdata = '0;
    logic [PDATA_BITS-1:0]  prdata;
    logic                   pready;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [1:0]             kind = '0;
    logic [7:0]             pix_x = '0;
    logic [7:0]             pix_y = '0;
    logic [2:0]             chan = '0;
    logic [31:0]            write_value = '0;
    logic signed [17:0]     coord_u = '0;
    logic signed [17:0]     coord_v = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [31:0]            read_value;
    logic [SAMPLE_BITS-1:0] sample_value;
    logic                   in_range;

    bit [31:0]      raster_mem [STORE_DEPTH];
    logic [7:0]     cfg_width = 8'd128;
    logic [7:0]     cfg_height = 8'd128;
    logic [2:0]     cfg_chans = 3'd4;
    raster_result_t awaited_results [$];
    directed_row_t  directed_rows [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off_left = 0;
    int mismatches = 0;
    int n_checked = 0;
    int n_writes = 0;
    int n_reads = 0;
    int n_samples = 0;
    int n_unused = 0;
    int n_out_of_range = 0;
    int n_geometries = 1;

    raster_bilinear_sampler i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .pix_x        (pix_x),
        .pix_y        (pix_y),
        .chan         (chan),
        .write_value  (write_value),
        .coord_u      (coord_u),
        .coord_v      (coord_v),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .read_value   (read_value),
        .sample_value (sample_value),
        .in_range     (in_range)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic bit [63:0] eff_dim(bit [63:0] value, int hi);
        if (value == 0)
        begin
            return 1;
        end
        if (value > hi)
        begin
            return hi;
        end
        return value;
    endfunction

    function automatic int elem_addr(bit [63:0] x, bit [63:0] y, bit [63:0] c);
        bit [63:0] w;
        bit [63:0] nc;
        w = eff_dim(cfg_width, MAX_W);
        nc = eff_dim(cfg_chans, MAX_C);
        return int'(((y * w + x) * nc + c) % STORE_DEPTH);
    endfunction

    function automatic bit [63:0] clamp_coord(logic signed [17:0] c);
        longint s;
        s = c;
        if (s < 0)
        begin
            return 0;
        end
        if (s > longint'(ONE_Q))
        begin
            return 64'(ONE_Q);
        end
        return 64'(s);
    endfunction

    // applies one transaction to the local store and returns its result
    function automatic raster_result_t raster_access(raster_txn_t t);
        raster_result_t r;
        bit [63:0] w, h, nc, one;
        bit [63:0] fx, fy, x0, y0, x1, y1, tx, ty;
        bit [63:0] v00, v10, v01, v11, top, bot, mix;
        r = '0;
        w = eff_dim(cfg_width, MAX_W);
        h = eff_dim(cfg_height, MAX_H);
        nc = eff_dim(cfg_chans, MAX_C);
        one = 64'(ONE_Q);
        if (t.kind == KIND_WRITE || t.kind == KIND_READ)
        begin
            if (t.x < w && t.y < h && t.ch < nc)
            begin
                r.ok = 1'b1;
                if (t.kind == KIND_WRITE)
                begin
                    raster_mem[elem_addr(t.x, t.y, t.ch)] = t.wval;
                end
                else
                begin
                    r.rd = raster_mem[elem_addr(t.x, t.y, t.ch)];
                end
            end
        end
        else if (t.kind == KIND_SAMPLE && t.ch < nc)
        begin
            fx = clamp_coord(t.u) * (w - 1);
            fy = clamp_coord(t.v) * (h - 1);
            x0 = fx >> FRAC_BITS;
            y0 = fy >> FRAC_BITS;
            tx = fx & (one - 1);
            ty = fy & (one - 1);
            x1 = (x0 + 1 < w) ? x0 + 1 : x0;
            y1 = (y0 + 1 < h) ? y0 + 1 : y0;
            v00 = raster_mem[elem_addr(x0, y0, t.ch)];
            v10 = raster_mem[elem_addr(x1, y0, t.ch)];
            v01 = raster_mem[elem_addr(x0, y1, t.ch)];
            v11 = raster_mem[elem_addr(x1, y1, t.ch)];
            top = v00 * (one - tx) + v10 * tx;
            bot = v01 * (one - tx) + v11 * tx;
            mix = (top * (one - ty) + bot * ty) >> FRAC_BITS;
            r.smp = mix[47:0];
            r.ok = 1'b1;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    function automatic int pick_pos(int lim);
        int r;
        r = $urandom_range(99);
        if (r < 40)
        begin
            return $urandom_range(((lim < 4) ? lim : 4) - 1);
        end
        if (r < 85)
        begin
            return $urandom_range(lim - 1);
        end
        return $urandom_range(255);
    endfunction

    function automatic logic signed [17:0] pick_coord();
        int r;
        r = $urandom_range(99);
        if (r < 15)
        begin
            return 18'($urandom);
        end
        if (r < 20)
        begin
            return '0;
        end
        if (r < 25)
        begin
            return 18'(ONE_Q);
        end
        if (r < 50)
        begin
            return 18'($urandom_range(2047));
        end
        return 18'($urandom_range(65536));
    endfunction

    function automatic raster_txn_t next_random_txn();
        raster_txn_t t;
        int r;
        int nc;
        nc = int'(eff_dim(cfg_chans, MAX_C));
        r = $urandom_range(99);
        if (r < 35)
        begin
            t.kind = KIND_WRITE;
        end
        else if (r < 65)
        begin
            t.kind = KIND_READ;
        end
        else if (r < 95)
        begin
            t.kind = KIND_SAMPLE;
        end
        else
        begin
            t.kind = KIND_UNUSED;
        end
        t.x = 8'(pick_pos(int'(eff_dim(cfg_width, MAX_W))));
        t.y = 8'(pick_pos(int'(eff_dim(cfg_height, MAX_H))));
        t.ch = ($urandom_range(99) < 85) ? 3'($urandom_range(nc - 1)) : 3'($urandom_range(7));
        r = $urandom_range(99);
        if (r < 70)
        begin
            t.wval = $urandom;
        end
        else if (r < 80)
        begin
            t.wval = '0;
        end
        else if (r < 90)
        begin
            t.wval = '1;
        end
        else
        begin
            t.wval = $urandom_range(255);
        end
        t.u = pick_coord();
        t.v = pick_coord();
        return t;
    endfunction

    task automatic add_row(input logic [1:0] k, input logic [7:0] x, input logic [7:0] y,
                           input logic [2:0] ch, input logic [31:0] wv,
                           input logic signed [17:0] u, input logic signed [17:0] v,
                           input logic fixed, input logic [31:0] rd,
                           input logic [47:0] smp, input logic ok);
        directed_row_t row;
        row.txn = '{k, x, y, ch, wv, u, v};
        row.fixed = fixed;
        row.res = '{rd, smp, ok};
        directed_rows.push_back(row);
    endtask

    task automatic send_txn(input raster_txn_t t, input logic fixed,
                            input raster_result_t fixed_res);
        raster_result_t want;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= t.kind;
        pix_x <= t.x;
        pix_y <= t.y;
        chan <= t.ch;
        write_value <= t.wval;
        coord_u <= t.u;
        coord_v <= t.v;
        do
            @(posedge clk);
        while (in_stall);
        want = raster_access(t);
        if (fixed)
        begin
            want = fixed_res;
        end
        awaited_results.push_back(want);
        case (t.kind)
            KIND_WRITE:  n_writes++;
            KIND_READ:   n_reads++;
            KIND_SAMPLE: n_samples++;
            default:     n_unused++;
        endcase
        if (t.kind != KIND_UNUSED && !want.ok)
        begin
            n_out_of_range++;
        end
    endtask

    task automatic flag_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("mismatch on %s: expected %0h, got %0h", field, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // register access
    // ------------------------------------------------------------------
    task automatic apb_write(input logic [PADDR_BITS-1:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_reg(input logic [PADDR_BITS-1:0] addr, input logic [31:0] want);
        logic [31:0] got;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        got = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (got !== want)
        begin
            flag_mismatch("register readback", want, got);
        end
    endtask

    task automatic wait_drained();
        while (awaited_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [7:0] w, input logic [7:0] h, input logic [2:0] c,
                             input int sidle, input int rstall, input int hold);
        wait_drained();
        apb_write(ADDR_WIDTH, 32'(w));
        apb_write(ADDR_HEIGHT, 32'(h));
        apb_write(ADDR_CHANS, 32'(c));
        check_reg(ADDR_WIDTH, 32'(w));
        check_reg(ADDR_HEIGHT, 32'(h));
        check_reg(ADDR_CHANS, 32'(c));
        cfg_width = w;
        cfg_height = h;
        cfg_chans = c;
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        hold_off_left = hold;
        n_geometries++;
        repeat (RANDOM_PER_PHASE) send_txn(next_random_txn(), 1'b0, '0);
        in_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_off_left > 0)
        begin
            out_stall <= 1'b1;
            hold_off_left = hold_off_left - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        raster_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
            begin
                flag_mismatch("unexpected transaction, read_value", '0, read_value);
            end
            else
            begin
                want = awaited_results.pop_front();
                n_checked++;
                if (read_value !== want.rd)
                begin
                    flag_mismatch("read_value", want.rd, read_value);
                end
                if (sample_value !== want.smp)
                begin
                    flag_mismatch("sample_value", want.smp, sample_value);
                end
                if (in_range !== want.ok)
                begin
                    flag_mismatch("in_range", want.ok, in_range);
                end
            end
        end
    end

    initial
    begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                stuck = 0;
            end
            else
            begin
                stuck++;
            end
        end
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        check_reg(ADDR_WIDTH, 32'd128);
        check_reg(ADDR_HEIGHT, 32'd128);
        check_reg(ADDR_CHANS, 32'd4);

        add_row(KIND_READ, 0, 0, 0, 0, 0, 0, 1, 0, 0, 1);
        add_row(KIND_READ, 127, 127, 3, 0, 0, 0, 1, 0, 0, 1);
        add_row(KIND_WRITE, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 1, 0, 0, 1);
        add_row(KIND_WRITE, 1, 0, 0, 32'h1234_5678, 0, 0, 1, 0, 0, 1);
        add_row(KIND_WRITE, 0, 1, 0, 32'h0000_8000, 0, 0, 1, 0, 0, 1);
        add_row(KIND_WRITE, 1, 1, 0, 32'h8000_0001, 0, 0, 1, 0, 0, 1);
        add_row(KIND_WRITE, 127, 127, 3, 32'hA5A5_A5A5, 0, 0, 1, 0, 0, 1);
        add_row(KIND_WRITE, 128, 0, 0, 32'hDEAD_BEEF, 0, 0, 1, 0, 0, 0);
        add_row(KIND_WRITE, 0, 255, 0, 32'hDEAD_BEEF, 0, 0, 1, 0, 0, 0);
        add_row(KIND_WRITE, 0, 0, 4, 32'hDEAD_BEEF, 0, 0, 1, 0, 0, 0);
        add_row(KIND_WRITE, 5, 5, 7, 32'hDEAD_BEEF, 0, 0, 1, 0, 0, 0);
        add_row(KIND_READ, 0, 0, 0, 0, 0, 0, 1, 32'hFFFF_FFFF, 0, 1);
        add_row(KIND_READ, 127, 127, 3, 0, 0, 0, 1, 32'hA5A5_A5A5, 0, 1);
        add_row(KIND_READ, 255, 0, 0, 0, 0, 0, 1, 0, 0, 0);
        add_row(KIND_READ, 0, 128, 0, 0, 0, 0, 1, 0, 0, 0);
        add_row(KIND_READ, 1, 1, 4, 0, 0, 0, 1, 0, 0, 0);
        add_row(KIND_SAMPLE, 0, 0, 0, 0, 0, 0, 1, 0, 48'hFFFF_FFFF_0000, 1);
        add_row(KIND_SAMPLE, 0, 0, 3, 0, 18'(ONE_Q), 18'(ONE_Q), 1, 0,
                48'hA5A5_A5A5_0000, 1);
        add_row(KIND_SAMPLE, 0, 0, 0, 0, 18'sh1FFFF, 18'sh20000, 0, 0, 0, 0);
        add_row(KIND_SAMPLE, 0, 0, 0, 0, 18'sd516, 18'sd260, 0, 0, 0, 0);
        add_row(KIND_SAMPLE, 0, 0, 0, 0, 18'sd32768, 18'sd49152, 0, 0, 0, 0);
        add_row(KIND_SAMPLE, 0, 0, 4, 0, 18'sh3FFFF, 18'(ONE_Q), 1, 0, 0, 0);
        add_row(KIND_SAMPLE, 0, 0, 7, 0, 18'(ONE_Q), 0, 1, 0, 0, 0);
        add_row(KIND_UNUSED, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
        add_row(KIND_UNUSED, 255, 255, 7, 32'hFFFF_FFFF, 18'sh1FFFF, 18'sh20000,
                1, 0, 0, 0);

        foreach (directed_rows[i])
        begin
            send_txn(directed_rows[i].txn, directed_rows[i].fixed, directed_rows[i].res);
        end
        repeat (150) send_txn(next_random_txn(), 1'b0, '0);
        in_valid <= 1'b0;

        run_phase(8'd8, 8'd8, 3'd2, 58, 0, 0);
        run_phase(8'd1, 8'd1, 3'd1, 0, 58, 0);
        run_phase(8'd0, 8'd0, 3'd0, 23, 23, 0);
        run_phase(8'd255, 8'd200, 3'd7, 0, 0, 0);
        run_phase(8'd3, 8'd5, 3'd3, 0, 0, HOLD_OFF_CYCLES);
        run_phase(8'd128, 8'd1, 3'd4, 0, 58, 0);
        run_phase(8'd16, 8'd4, 3'd1, 23, 23, 0);
        run_phase(8'd2, 8'd2, 3'd4, 58, 0, 0);
        run_phase(8'd128, 8'd128, 3'd4, 23, 23, 0);
        wait_drained();

        $display("covered %0d writes, %0d reads, %0d samples, %0d unused-kind transactions",
                 n_writes, n_reads, n_samples, n_unused);
        $display("%0d out of range, %0d geometries, %0d results compared, %0d mismatches",
                 n_out_of_range, n_geometries, n_checked, mismatches);
        if (mismatches == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
